/* hdl/thread_scheduler_queues_defines.svh */
// Assertion macros shared by the scheduler checker.
// No dependencies.
`ifndef THREAD_SCHEDULER_QUEUES_DEFINES_SVH
`define THREAD_SCHEDULER_QUEUES_DEFINES_SVH
// Implication under synchronous reset.
`define TSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under synchronous reset.
`define TSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/tsq_pkg.sv */
// Shared types and constants of the thread scheduler.
// No dependencies.
package tsq_pkg;
    localparam int MaxThreads = 16;
    localparam int NumWaitQueues = 8;
    localparam int TidW = 4;
    localparam int CntW = 5;
    localparam int WqW = 3;

    localparam logic [2:0] REQ_CREATE = 3'd0;
    localparam logic [2:0] REQ_YIELD  = 3'd1;
    localparam logic [2:0] REQ_EXIT   = 3'd2;
    localparam logic [2:0] REQ_KILL   = 3'd3;
    localparam logic [2:0] REQ_SLEEP  = 3'd4;
    localparam logic [2:0] REQ_WAKE   = 3'd5;

    localparam logic [1:0] KIND_NAMED = 2'd0;
    localparam logic [1:0] KIND_ANY   = 2'd1;
    localparam logic [1:0] KIND_SELF  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NOMORE  = 2'd3;

    typedef struct packed {
        logic [2:0]      req;
        logic [TidW-1:0] target;
        logic [1:0]      kind;
        logic [WqW-1:0]  wq;
        logic            all;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [TidW-1:0] rtid;
        logic [TidW-1:0] running;
        logic [CntW-1:0] woken;
    } t_res;
endpackage

/* hdl/tsq_front.sv */
// Front end: takes request words and queues them for the executor.
// Depends on tsq_pkg.
module tsq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tsq_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output tsq_pkg::t_req  o_req
);
    import tsq_pkg::*;
    // two-entry queue
    t_req r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_req;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* hdl/tsq_exec.sv */
// Executor: sequencer that serves each request, walking the shared link memory for yield and kill.
// Depends on tsq_pkg.
module tsq_exec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tsq_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output tsq_pkg::t_res  o_res
);
    import tsq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_RD   = 6'b000100,
        S_WAKE = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_st;
    t_req r_rq;
    logic [TidW-1:0] r_link [MaxThreads];
    logic [TidW-1:0] r_free [MaxThreads];
    logic [TidW-1:0] r_rhead, r_rtail;
    logic [CntW-1:0] r_rcnt;
    logic [TidW-1:0] r_whead [NumWaitQueues];
    logic [TidW-1:0] r_wtail [NumWaitQueues];
    logic [CntW-1:0] r_wcnt [NumWaitQueues];
    logic [TidW-1:0] r_rcl_tid;
    logic r_rcl_v;
    logic [CntW-1:0] r_fcnt, r_live;
    logic [TidW-1:0] r_cur;
    // walk state
    logic [TidW-1:0] r_t, r_cur_w, r_prev;
    logic [CntW-1:0] r_i;
    t_res r_res;

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_res = r_res;

    logic [TidW-1:0] rd_next;
    assign rd_next = r_link[r_cur_w];
    logic [WqW-1:0] wq;
    assign wq = r_rq.wq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_rhead <= '0; r_rtail <= '0; r_rcnt <= '0;
            for (int k = 0; k < NumWaitQueues; k++) begin
                r_whead[k] <= '0; r_wtail[k] <= '0; r_wcnt[k] <= '0;
            end
            r_rcl_tid <= '0; r_rcl_v <= 1'b0;
            r_fcnt <= '0; r_live <= CntW'(1); r_cur <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_rq <= i_req;
                    r_res <= '{status: ST_OK, rtid: '0, running: r_cur, woken: '0};
                    r_st <= S_FIN;
                    r_i <= '0;
                    r_cur_w <= r_rhead;
                    r_prev <= '0;
                    case (i_req.req)
                        REQ_CREATE: begin
                            if (r_live >= CntW'(MaxThreads)) begin
                                r_res.status <= ST_NOMORE;
                            end else begin
                                logic [TidW-1:0] t;
                                t = (r_fcnt == '0) ? r_live[TidW-1:0]
                                                   : r_free[r_fcnt[TidW-1:0] - 1'b1];
                                if (r_fcnt != '0) r_fcnt <= r_fcnt - 1'b1;
                                r_live <= r_live + 1'b1;
                                if (r_rcnt == '0) r_rhead <= t;
                                else r_link[r_rtail] <= t;
                                r_rtail <= t;
                                r_rcnt <= r_rcnt + 1'b1;
                                r_res.rtid <= t;
                            end
                        end
                        REQ_YIELD, REQ_EXIT, REQ_KILL: begin
                            // reclaim an exited thread first
                            logic [CntW-1:0] lv;
                            lv = r_live;
                            if (r_rcl_v) begin
                                if (r_fcnt < CntW'(MaxThreads)) begin
                                    r_free[r_fcnt[TidW-1:0]] <= r_rcl_tid;
                                    r_fcnt <= r_fcnt + 1'b1;
                                end
                                if (r_live != '0) lv = r_live - 1'b1;
                                r_rcl_v <= 1'b0;
                            end
                            r_live <= lv;
                            if (i_req.req == REQ_EXIT) begin
                                if (r_rcnt == '0) begin
                                    r_res.status <= ST_NONE;
                                end else begin
                                    r_res.rtid <= r_cur;
                                    r_rcl_tid <= r_cur;
                                    r_rcl_v <= 1'b1;
                                    r_cur <= r_rhead;
                                    r_res.running <= r_rhead;
                                    r_rcnt <= r_rcnt - 1'b1;
                                    r_st <= S_RD;
                                end
                            end else if (i_req.req == REQ_KILL) begin
                                r_t <= i_req.target;
                                r_res.rtid <= i_req.target;
                                r_st <= S_SCAN;
                            end else if (i_req.kind == KIND_ANY && r_rcnt == '0) begin
                                r_res.status <= ST_NONE;
                            end else if (i_req.kind == KIND_SELF ||
                                         (i_req.kind == KIND_ANY ? r_rhead : i_req.target)
                                         == r_cur) begin
                                r_res.rtid <= r_cur;
                            end else begin
                                r_t <= (i_req.kind == KIND_ANY) ? r_rhead : i_req.target;
                                r_st <= S_SCAN;
                            end
                        end
                        REQ_SLEEP: begin
                            if (32'(i_req.wq) >= NumWaitQueues) r_res.status <= ST_INVALID;
                            else if (r_rcnt == '0) r_res.status <= ST_NONE;
                            else begin
                                if (r_wcnt[i_req.wq] < CntW'(MaxThreads)) begin
                                    if (r_wcnt[i_req.wq] == '0) r_whead[i_req.wq] <= r_cur;
                                    else r_link[r_wtail[i_req.wq]] <= r_cur;
                                    r_wtail[i_req.wq] <= r_cur;
                                    r_wcnt[i_req.wq] <= r_wcnt[i_req.wq] + 1'b1;
                                end
                                r_cur <= r_rhead;
                                r_res.rtid <= r_rhead;
                                r_res.running <= r_rhead;
                                r_rcnt <= r_rcnt - 1'b1;
                                r_st <= S_RD;
                            end
                        end
                        REQ_WAKE: begin
                            if (32'(i_req.wq) < NumWaitQueues) r_st <= S_WAKE;
                        end
                        default: ;
                    endcase
                end
                S_RD: begin
                    // advance ready head after a pop
                    if (r_rcnt != '0) r_rhead <= r_link[r_rhead];
                    r_st <= S_OUT;
                end
                S_SCAN: begin
                    // one list link per cycle looking for r_t
                    if (r_i >= r_rcnt) begin
                        r_res.status <= ST_INVALID;
                        r_res.rtid <= r_t;
                        r_st <= S_OUT;
                    end else if (r_cur_w == r_t) begin
                        logic [TidW-1:0] h, tl;
                        logic [CntW-1:0] c;
                        h = r_rhead; tl = r_rtail; c = r_rcnt - 1'b1;
                        if (r_i == '0) h = rd_next;
                        else if (r_i + 1'b1 == r_rcnt) tl = r_prev;
                        // removing the tail leaves the old link past the end
                        else r_link[r_prev] <= rd_next;
                        if (r_rq.req == REQ_KILL) begin
                            if (r_fcnt < CntW'(MaxThreads)) begin
                                r_free[r_fcnt[TidW-1:0]] <= r_t;
                                r_fcnt <= r_fcnt + 1'b1;
                            end
                            if (r_live != '0) r_live <= r_live - 1'b1;
                        end else begin
                            // push the caller at the tail
                            if (c == '0) h = r_cur;
                            else r_link[tl] <= r_cur;
                            tl = r_cur;
                            c = c + 1'b1;
                            r_cur <= r_t;
                            r_res.rtid <= r_t;
                            r_res.running <= r_t;
                        end
                        r_rhead <= h; r_rtail <= tl; r_rcnt <= c;
                        r_st <= S_OUT;
                    end else begin
                        r_prev <= r_cur_w;
                        r_cur_w <= rd_next;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_WAKE: begin
                    // move one waiter per cycle
                    if (r_wcnt[wq] == '0 || (!r_rq.all && r_res.woken != '0)) begin
                        r_st <= S_OUT;
                    end else begin
                        logic [TidW-1:0] t;
                        t = r_whead[wq];
                        r_wcnt[wq] <= r_wcnt[wq] - 1'b1;
                        if (r_wcnt[wq] != CntW'(1)) r_whead[wq] <= r_link[t];
                        if (r_rcnt < CntW'(MaxThreads)) begin
                            if (r_rcnt == '0) r_rhead <= t;
                            else r_link[r_rtail] <= t;
                            r_rtail <= t;
                            r_rcnt <= r_rcnt + 1'b1;
                        end
                        r_res.woken <= r_res.woken + 1'b1;
                    end
                end
                S_FIN: r_st <= S_OUT;
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/thread_scheduler_queues.sv */
// Top level of the hardware thread scheduler.
// Depends on tsq_pkg, tsq_front, tsq_exec.
//
//  channel   dir  payload
//  s_axis    in   request word (req_type, target_tid, target_kind, wait_queue, wake_all)
//  m_axis    out  result word (status, result_tid, running_tid, woken_count)
//
// Sequencing: create, exit, sleep and the other one-step requests need no list walk;
// yield and kill walk the ready list one link a cycle; wake-all moves one waiter
// a cycle.
// The executor handles one word at a time; the front queue holds two more.
// Reset: synchronous; thread 0 runs, all queues empty.
// Result is held until m_axis_tready.
module thread_scheduler_queues (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] req_type, [6:3] target_tid, [8:7] target_kind, [11:9] wait_queue,
    // [12] wake_all, [15:13] zero
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [5:2] result_tid, [9:6] running_tid, [14:10] woken_count, [15] zero
    output logic [15:0] m_axis_tdata
);
    import tsq_pkg::*;
    t_req in_req, q_req;
    t_res res;
    logic q_valid, q_ready;

    assign in_req.req    = s_axis_tdata[2:0];
    assign in_req.target = s_axis_tdata[6:3];
    assign in_req.kind   = s_axis_tdata[8:7];
    assign in_req.wq     = s_axis_tdata[11:9];
    assign in_req.all    = s_axis_tdata[12];

    tsq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(in_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );
    tsq_exec u_exec (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );
    assign m_axis_tdata = {1'b0, res.woken, res.running, res.rtid, res.status};
endmodule

/* hdl/tsq_checker.sv */
// Port-level checker for the scheduler, bound to the top level.
// Depends on thread_scheduler_queues_defines.svh.
`include "thread_scheduler_queues_defines.svh"
module tsq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    `TSQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `TSQ_ASSERT_IMP(a_pad, i_clk, i_rst_n, m_axis_tvalid, !m_axis_tdata[15])
    `TSQ_ASSERT_IMP(a_wake_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[14:10] != 5'd0, m_axis_tdata[1:0] == 2'd0)
    `TSQ_ASSERT_NXT(a_no_back, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
endmodule

bind thread_scheduler_queues tsq_checker u_tsq_checker (.*);

/* bench/testbench.sv */
// Self-checking bench for the thread scheduler: random and directed requests,
// each result checked against a behavioral scheduler model kept in the bench.
// Depends on tsq_pkg and thread_scheduler_queues.
module testbench;
    import tsq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // [2:0] req, [6:3] tid, [8:7] kind, [11:9] wq, [12] all
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // [1:0] status, [5:2] tid, [9:6] running, [14:10] woken

    thread_scheduler_queues dut (.*);

    always #10 i_clk = ~i_clk;

    // scheduler model state
    logic [3:0] nxt [MaxThreads];
    logic [3:0] rq_head, rq_tail;
    int         rq_cnt;
    logic [3:0] wq_head [NumWaitQueues];
    logic [3:0] wq_tail [NumWaitQueues];
    int         wq_cnt [NumWaitQueues];
    logic [3:0] zombie;
    bit         zombie_ok;
    logic [3:0] free_stk [MaxThreads];
    int         free_cnt, live, running;

    t_res  sched_expected [$];
    int    send_idle_pct = 0, recv_stall_pct = 0;
    bit    failed = 0;

    task automatic sched_init();
        rq_head = 0; rq_tail = 0; rq_cnt = 0;
        foreach (wq_cnt[i]) begin
            wq_head[i] = 0; wq_tail[i] = 0; wq_cnt[i] = 0;
        end
        zombie = 0; zombie_ok = 0; free_cnt = 0; live = 1; running = 0;
    endtask

    // push/pop on the ready queue (q=-1) or wait queue q
    task automatic list_push(int q, logic [3:0] t);
        int c;
        c = (q < 0) ? rq_cnt : wq_cnt[q];
        if (c >= MaxThreads) return;
        if (q < 0) begin
            if (c == 0) rq_head = t; else nxt[rq_tail] = t;
            rq_tail = t; rq_cnt++;
        end else begin
            if (c == 0) wq_head[q] = t; else nxt[wq_tail[q]] = t;
            wq_tail[q] = t; wq_cnt[q]++;
        end
    endtask

    function automatic logic [3:0] list_pop(int q);
        logic [3:0] t;
        if (q < 0) begin
            t = rq_head;
            if (rq_cnt == 0) return 0;
            rq_cnt--;
            if (rq_cnt > 0) rq_head = nxt[t];
        end else begin
            t = wq_head[q];
            if (wq_cnt[q] == 0) return 0;
            wq_cnt[q]--;
            if (wq_cnt[q] > 0) wq_head[q] = nxt[t];
        end
        return t;
    endfunction

    function automatic bit ready_unlink(logic [3:0] t);
        logic [3:0] cur, prev;
        cur = rq_head; prev = 0;
        for (int i = 0; i < rq_cnt; i++) begin
            if (cur == t) begin
                if (i == 0) rq_head = nxt[cur];
                else begin
                    nxt[prev] = nxt[cur];
                    if (i + 1 == rq_cnt) rq_tail = prev;
                end
                rq_cnt--;
                return 1;
            end
            prev = cur;
            cur = nxt[cur];
        end
        return 0;
    endfunction

    task automatic release_id(logic [3:0] t);
        if (free_cnt < MaxThreads) begin
            free_stk[free_cnt] = t; free_cnt++;
        end
        if (live > 0) live--;
    endtask

    task automatic reap_zombie();
        if (zombie_ok) begin
            release_id(zombie); zombie_ok = 0;
        end
    endtask

    task automatic sched_predict(t_req r, output t_res o);
        logic [3:0] t;
        o = '0;
        case (r.req)
            REQ_CREATE: begin
                if (live >= MaxThreads) o.status = ST_NOMORE;
                else begin
                    if (free_cnt == 0) t = live[3:0];
                    else begin
                        free_cnt--; t = free_stk[free_cnt];
                    end
                    live++;
                    list_push(-1, t);
                    o.rtid = t;
                end
            end
            REQ_YIELD: begin
                reap_zombie();
                t = r.target;
                if (r.kind == KIND_ANY && rq_cnt == 0) o.status = ST_NONE;
                else begin
                    if (r.kind == KIND_ANY) t = rq_head;
                    if (r.kind == KIND_SELF || t == running) o.rtid = running;
                    else if (!ready_unlink(t)) begin
                        o.status = ST_INVALID; o.rtid = t;
                    end else begin
                        list_push(-1, running);
                        running = t; o.rtid = t;
                    end
                end
            end
            REQ_EXIT: begin
                reap_zombie();
                if (rq_cnt == 0) o.status = ST_NONE;
                else begin
                    o.rtid = running; zombie = running; zombie_ok = 1;
                    running = list_pop(-1);
                end
            end
            REQ_KILL: begin
                reap_zombie();
                o.rtid = r.target;
                if (!ready_unlink(r.target)) o.status = ST_INVALID;
                else release_id(r.target);
            end
            REQ_SLEEP: begin
                if (r.wq >= NumWaitQueues) o.status = ST_INVALID;
                else if (rq_cnt == 0) o.status = ST_NONE;
                else begin
                    t = list_pop(-1);
                    list_push(r.wq, running);
                    running = t; o.rtid = t;
                end
            end
            REQ_WAKE: begin
                if (r.wq < NumWaitQueues) begin
                    while (wq_cnt[r.wq] > 0) begin
                        t = list_pop(r.wq);
                        list_push(-1, t);
                        o.woken++;
                        if (!r.all) break;
                    end
                end
            end
            default: ;
        endcase
        o.running = running[3:0];
    endtask

    // one request word: predict, then hold it until accepted;
    // valid stays high after the accept unless the sender idles
    task automatic send_request(t_req r);
        t_res o;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        sched_predict(r, o);
        sched_expected.push_back(o);
        s_axis_tdata  <= {3'b0, r.all, r.wq, r.kind, r.target, r.req};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_req mk(logic [2:0] q, logic [3:0] t, logic [1:0] k,
                                logic [2:0] w, logic a);
        t_req r;
        r.req = q; r.target = t; r.kind = k; r.wq = w; r.all = a;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res got, exp;
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[9:6],
                       m_axis_tdata[14:10]};
                if (sched_expected.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    failed = 1;
                end else begin
                    exp = sched_expected.pop_front();
                    if (got !== exp) begin
                        $display("%0t: mismatch expected st=%0d tid=%0d run=%0d woken=%0d",
                                 $time, exp.status, exp.rtid, exp.running, exp.woken);
                        $display("%0t:          actual   st=%0d tid=%0d run=%0d woken=%0d",
                                 $time, got.status, got.rtid, got.running, got.woken);
                        failed = 1;
                    end
                end
            end
        end
    end

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sched_expected.size() != 0) @(posedge i_clk);
    endtask

    // every request kind, full table, unknown codes
    task automatic test_directed();
        send_request(mk(REQ_YIELD, 0, KIND_ANY, 0, 0));    // nothing ready
        send_request(mk(REQ_EXIT, 0, KIND_NAMED, 0, 0));   // nothing ready
        send_request(mk(REQ_SLEEP, 0, KIND_NAMED, 0, 0));  // nothing ready
        for (int i = 0; i < 16; i++)                       // last one overflows
            send_request(mk(REQ_CREATE, 0, 0, 0, 0));
        send_request(mk(REQ_YIELD, 15, KIND_NAMED, 0, 0));
        send_request(mk(REQ_YIELD, 15, KIND_NAMED, 0, 0)); // self by name
        send_request(mk(REQ_YIELD, 3, KIND_SELF, 0, 0));
        send_request(mk(REQ_YIELD, 2, 2'd3, 0, 0));        // kind 3 acts named
        send_request(mk(REQ_KILL, 15, 0, 0, 0));           // running: invalid
        send_request(mk(REQ_KILL, 5, 0, 0, 0));
        send_request(mk(REQ_SLEEP, 0, 0, 7, 0));
        send_request(mk(REQ_SLEEP, 0, 0, 7, 1));
        send_request(mk(REQ_EXIT, 0, 0, 0, 0));
        send_request(mk(REQ_CREATE, 0, 0, 0, 0));          // reuses a freed id
        send_request(mk(REQ_WAKE, 0, 0, 7, 0));
        send_request(mk(REQ_WAKE, 0, 0, 7, 1));
        send_request(mk(REQ_WAKE, 0, 0, 3, 1));            // empty queue
        send_request(mk(3'd6, 4'hf, 2'd3, 7, 1));
        send_request(mk(3'd7, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_random(int n, int idle, int stall);
        t_req r;
        send_idle_pct = idle; recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            r.req    = ($urandom_range(99) < 3) ? 3'($urandom_range(7, 6))
                                                 : 3'($urandom_range(5));
            r.target = 4'($urandom_range(15));
            r.kind   = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
            r.wq     = 3'($urandom_range(7));
            r.all    = 1'($urandom_range(1));
            send_request(r);
        end
        drain();  // sender holds off until every result has come
    endtask

    initial begin
        sched_init();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500, 0, 0);
        test_random(500, 50, 0);
        test_random(500, 0, 50);
        test_random(500, 21, 21);
        repeat (50) @(posedge i_clk);
        if (!failed && sched_expected.size() == 0)
            $display("** thread_scheduler_queues: PASSED **");
        else
            $display("** thread_scheduler_queues: FAILED **");
        $finish;
    end

    initial begin
        #20000000;
        $display("** thread_scheduler_queues: FAILED **");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/tsq_pkg.sv
hdl/tsq_front.sv
hdl/tsq_exec.sv
hdl/thread_scheduler_queues.sv
hdl/tsq_checker.sv
bench/testbench.sv
